>>> rtl/cle_pkg.sv
// Shared types and codes for the capped list engine.
`timescale 1ns / 1ps
`default_nettype none
package cle_pkg;
  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_DELETE  = 2'd1;
  localparam logic [1:0] ACT_GET     = 2'd2;
  localparam logic [1:0] ACT_GET_DEL = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_OOR    = 3'd1;
  localparam logic [2:0] ST_OVFL   = 3'd2;
  localparam logic [2:0] ST_NOELEM = 3'd3;
  localparam logic [2:0] ST_UNREAD = 3'd4;

  localparam logic [1:0] REG_MAX_COUNT = 2'd0;
  localparam logic [1:0] REG_OVERFLOW  = 2'd1;
  localparam logic [1:0] REG_READABLE  = 2'd2;

  localparam logic [1:0] OVF_REJECT    = 2'd0;
  localparam logic [1:0] OVF_TRIM_HEAD = 2'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_WALK,
    S_RESULT
  } state_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;   // cell at pos takes the new value, cells above it the left neighbor
    logic del;   // cells at or above pos take the right neighbor
  } cell_cmd_t;
endpackage
`default_nettype wire

>>> rtl/cle_cell.sv
// One storage cell of the shifting element chain.
`timescale 1ns / 1ps
`default_nettype none
module cle_cell
  import cle_pkg::*;
#(
  parameter int VW = 32
) (
  input  wire           clk,
  input  cell_cmd_t     cmd,
  input  wire           at_or_above,
  input  wire           at_pos,
  input  wire  [VW-1:0] new_value,
  input  wire  [VW-1:0] left_value,
  input  wire  [VW-1:0] right_value,
  output logic [VW-1:0] value
);
  always_ff @(posedge clk) begin
    if (cmd.ins && at_pos) begin
      value <= new_value;
    end else if (cmd.ins && at_or_above) begin
      value <= left_value;
    end else if (cmd.del && at_or_above) begin
      value <= right_value;
    end
  end
endmodule
`default_nettype wire

>>> rtl/capped_list_engine_core.sv
// Top level of the capped list engine: control sequencer and cell chain.
// The block holds an ordered list of up to LIST_DEPTH values in a row of
// cells. Each cell shifts toward its neighbor for an insert or a single
// removal. Input words arrive on a valid/ready channel (action,
// first_index, last_index, value); result words leave on a valid/ready
// channel (status, out_value, item_count, last).
// An insert shifts its value into the chain, after a trim shift when a full
// list trims instead of rejecting, and then presents its result word. A
// delete of n elements shifts the chain once per element and then presents
// its result word. A get presents its result words from the walk, one per
// cycle while the receiver takes them; a get with delete removes each
// element as its word is taken. One input word is in work at a time and
// in_ready is high only when idle, which is entered in the cycle after the
// final result word is taken.
// When the receiver stalls, the current result word holds and the walk
// pauses. Reset empties the list and loads the register defaults
// (max_count 64, overflow_action 2, readable 1). The APB port writes in
// its access cycle and always has pready high.
`timescale 1ns / 1ps
`default_nettype none
module capped_list_engine_core
  import cle_pkg::*;
#(
  parameter int LIST_DEPTH  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [3:0]             paddr,
  input  wire  [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  [1:0]             action,
  input  wire  signed [7:0]      first_index,
  input  wire  signed [7:0]      last_index,
  input  wire  [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [2:0]             status,
  output logic [31:0]            out_value,
  output logic [6:0]             item_count,
  output logic                   last
);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = $clog2(LIST_DEPTH);
  localparam int IW = (CW > 8 ? CW : 8) + 2;

  logic [6:0] max_count;
  logic [1:0] overflow_action;
  logic       readable;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_count       <= 7'd64;
      overflow_action <= 2'd2;
      readable        <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MAX_COUNT: max_count       <= pwdata[6:0];
        REG_OVERFLOW:  overflow_action <= pwdata[1:0];
        REG_READABLE:  readable        <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_MAX_COUNT: prdata[6:0] = max_count;
      REG_OVERFLOW:  prdata[1:0] = overflow_action;
      REG_READABLE:  prdata[0]   = readable;
      default: ;
    endcase
  end

  // Cell chain.
  logic [VALUE_WIDTH-1:0] cells [LIST_DEPTH];
  cell_cmd_t              cmd;
  logic [AW-1:0]          pos;
  logic [VALUE_WIDTH-1:0] ins_value;

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    cle_cell #(.VW(VALUE_WIDTH)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .at_or_above(AW'(g) >= pos),
      .at_pos     (AW'(g) == pos),
      .new_value  (ins_value),
      .left_value (g == 0 ? ins_value : cells[(g == 0) ? 0 : g-1]),
      .right_value(g == LIST_DEPTH-1 ? cells[g] : cells[(g == LIST_DEPTH-1) ? g : g+1]),
      .value      (cells[g])
    );
  end

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [1:0]    act;
  logic signed [IW-1:0] ins_idx;
  logic          trim_pend, trim_head;
  logic [CW-1:0] walk_pos, walk_end, done_n;
  logic          walk_back;
  logic [2:0]    res_status;
  logic [6:0]    res_count;

  // Decode of the incoming word (combinational, at acceptance).
  logic [CW-1:0] m;
  logic signed [IW-1:0] c_s, m_s, fi, li, f2, t2, span;
  logic oor, full, no_elem, d_trim_head;
  logic signed [IW-1:0] adj_idx;
  logic [2:0] d_status;
  logic [6:0] d_count;
  always_comb begin
    m = (max_count == 7'd0 || int'(max_count) > LIST_DEPTH) ?
        CW'(LIST_DEPTH) : CW'(max_count);
    c_s = IW'(count);
    m_s = IW'(m);
    fi  = IW'(first_index);
    li  = IW'(last_index);
    if (fi >= 0) oor = (fi > c_s) || (fi > m_s - 1);
    else         oor = (-fi > c_s + 1) || (-fi > m_s);
    full = c_s >= m_s;
    d_trim_head = (fi == -1) ? 1'b1 : (fi == 0) ? 1'b0 :
                  (overflow_action == OVF_TRIM_HEAD);
    adj_idx = fi;
    if (full && overflow_action != OVF_REJECT && fi != 0 && fi != -1) begin
      if (d_trim_head && fi > 0) adj_idx = fi - 1;
      if (!d_trim_head && fi < 0) adj_idx = fi + 1;
    end
    f2 = (fi < 0) ? fi + c_s : fi;
    t2 = (li < 0) ? li + c_s : li;
    no_elem = (count == '0) || (f2 < 0 && t2 < 0) || (f2 >= c_s && t2 >= c_s);
    if (f2 < 0) f2 = '0; else if (f2 >= c_s) f2 = c_s - 1;
    if (t2 < 0) t2 = '0; else if (t2 >= c_s) t2 = c_s - 1;
    span = (f2 <= t2) ? t2 - f2 + IW'(1) : f2 - t2 + IW'(1);
    if (action == ACT_INSERT) begin
      d_count = 7'(count);
      if (oor) d_status = ST_OOR;
      else if (full && overflow_action == OVF_REJECT) d_status = ST_OVFL;
      else d_status = ST_OK;
    end else if (action != ACT_DELETE && !readable) begin
      d_status = ST_UNREAD;
      d_count  = '0;
    end else if (no_elem) begin
      d_status = ST_NOELEM;
      d_count  = '0;
    end else begin
      d_status = ST_OK;
      d_count  = (action == ACT_DELETE) ? 7'(span) : '0;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_WALK) || (state == S_RESULT);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_APPLY;
      S_APPLY: begin
        if (trim_pend) begin
          state_next = S_APPLY;
        end else if (act == ACT_DELETE && res_status == ST_OK && done_n > CW'(1)) begin
          state_next = S_APPLY;
        end else if ((act == ACT_GET || act == ACT_GET_DEL) && res_status == ST_OK) begin
          state_next = S_WALK;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_WALK:   if (out_ready && walk_pos == walk_end) state_next = S_IDLE;
      S_RESULT: if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  logic walk_del;
  assign walk_del = (state == S_WALK) && out_ready && (act == ACT_GET_DEL);

  // Chain command and position for the current cycle.
  logic signed [IW-1:0] ins_pos;
  always_comb begin
    cmd = '0;
    pos = '0;
    ins_pos = (ins_idx < 0) ? ins_idx + c_s + 1 : ins_idx;
    if (ins_pos < 0) ins_pos = '0;
    if (ins_pos > c_s) ins_pos = c_s;
    if (state == S_APPLY && act == ACT_INSERT) begin
      if (trim_pend) begin
        cmd.del = 1'b1;
        pos = trim_head ? '0 : AW'(count - 1'b1);
      end else if (res_status == ST_OK) begin
        cmd.ins = 1'b1;
        pos = AW'(ins_pos);
      end
    end else if (state == S_APPLY && act == ACT_DELETE && res_status == ST_OK
                 && done_n != '0) begin
      cmd.del = 1'b1;
      pos = AW'(walk_pos);
    end else if (walk_del) begin
      cmd.del = 1'b1;
      pos = AW'(walk_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (cmd.ins) count <= count + 1'b1;
      else if (cmd.del) count <= count - 1'b1;
    end
  end

  // Result word in S_WALK comes from the cell at walk_pos.
  always_comb begin
    status     = res_status;
    out_value  = '0;
    item_count = res_count;
    last       = 1'b1;
    if (state == S_WALK) begin
      status     = ST_OK;
      out_value  = 32'(cells[AW'(walk_pos)]);
      item_count = '0;
      last       = (walk_pos == walk_end);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      act        <= action;
      ins_value  <= value;
      ins_idx    <= adj_idx;
      trim_head  <= d_trim_head;
      trim_pend  <= (action == ACT_INSERT) && (d_status == ST_OK) && full;
      res_status <= d_status;
      res_count  <= d_count;
      walk_back  <= f2 > t2;
      // A range delete shifts out its lower end repeatedly.
      walk_pos   <= (action == ACT_DELETE && f2 > t2) ? CW'(t2) : CW'(f2);
      walk_end   <= CW'(t2);
      done_n     <= (action == ACT_DELETE && d_status == ST_OK) ? CW'(span) : '0;
    end else if (state == S_APPLY) begin
      if (act == ACT_INSERT) begin
        if (trim_pend) trim_pend <= 1'b0;
        else if (res_status == ST_OK) res_count <= 7'(count + 1'b1);
      end else if (act == ACT_DELETE && res_status == ST_OK && done_n != '0) begin
        done_n <= done_n - 1'b1;
      end
    end else if (state == S_WALK && out_ready) begin
      // A deleting forward walk stays put as the rest of the list shifts down into its place.
      if (walk_back) begin
        walk_pos <= walk_pos - 1'b1;
      end else if (act == ACT_GET_DEL) begin
        walk_end <= walk_end - 1'b1;
      end else begin
        walk_pos <= walk_pos + 1'b1;
      end
      if (walk_back && act == ACT_GET_DEL) walk_end <= walk_end;
    end
  end
endmodule
`default_nettype wire
